[rtl/foc_current_loop_defines.svh]
// Assertion macros for the current loop modules; included by foc_ctrl.
// No dependencies.
`ifndef FOC_CURRENT_LOOP_DEFINES_SVH
`define FOC_CURRENT_LOOP_DEFINES_SVH
// implication checked on every clock edge outside reset
`define FOC_ASSERT_IMP(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
else $error(msg);
// next-cycle implication
`define FOC_ASSERT_NEXT(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
else $error(msg);
`endif

[rtl/foc_pkg.sv]
// Package for the FOC current loop: types, constants, sine table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package foc_pkg;
	localparam int SineTableDepth = 256;
	localparam int SineIdxW = $clog2(SineTableDepth);
	localparam int DutyBits = 12;
	localparam logic signed [17:0] SinA = 18'sd51472;
	localparam logic signed [17:0] SinB = 18'sd21315;
	localparam logic signed [17:0] SinC = 18'sd2611;
	localparam logic signed [17:0] InvSqrt3 = 18'sd18919;
	localparam logic signed [17:0] HalfSqrt3 = 18'sd28378;
	localparam logic signed [17:0] MinusHalf = -18'sd16384;

	localparam logic [1:0] RegKp = 2'd0;
	localparam logic [1:0] RegKi = 2'd1;
	localparam logic [1:0] RegDRef = 2'd2;
	localparam logic [1:0] RegQRef = 2'd3;

	typedef struct packed {
		logic signed [15:0] phase_a_current;
		logic signed [15:0] phase_b_current;
		logic signed [15:0] angle_step;
	} in_item_t;

	typedef struct packed {
		logic [11:0] duty_a;
		logic [11:0] duty_b;
		logic [11:0] duty_c;
		logic signed [15:0] current_d;
		logic signed [15:0] current_q;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_HOLD
	} ctl_state_t;

	// one microcode step per cycle while the sequencer is in its run state
	typedef struct packed {
		logic start;
		logic step;
		logic [5:0] pc;
	} dp_cmd_t;

	typedef struct packed {
		logic last;
	} dp_sts_t;

	localparam logic [5:0] LastPc = 6'd40;

	function automatic logic signed [63:0] rshr(input logic signed [63:0] x,
			input int k);
		logic signed [63:0] y;
		y = x + (64'sd1 <<< (k - 1));
		return y >>> k;
	endfunction

	function automatic logic signed [63:0] sat16(input logic signed [63:0] x);
		logic signed [63:0] r;
		if (x > 64'sd32767) r = 64'sd32767;
		else if (x < -64'sd32768) r = -64'sd32768;
		else r = x;
		return r;
	endfunction

	// sine entry for table index k, computed at elaboration (constant table)
	function automatic logic signed [17:0] sine_entry(input int k);
		longint ph, quad, r, z, z2, t;
		ph = (longint'(k) * 65536) / SineTableDepth;
		quad = (ph >> 14) & 3;
		r = ph & 16'h3FFF;
		z = ((quad & 1) != 0) ? (16384 - r) * 2 : r * 2;
		z2 = rshr(z * z, 15);
		t = 21315 - rshr(2611 * z2, 15);
		t = 51472 - rshr(t * z2, 15);
		t = rshr(t * z, 15);
		return ((quad & 2) != 0) ? 18'(-t) : 18'(t);
	endfunction
endpackage
`default_nettype wire

[rtl/foc_ctrl.sv]
// Sequencer for the FOC datapath: accepts a request, steps the microcode.
// Depends on foc_pkg and foc_current_loop_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "foc_current_loop_defines.svh"
module foc_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  wire logic out_stall,
	output foc_pkg::dp_cmd_t cmd,
	input  wire foc_pkg::dp_sts_t sts
);
	foc_pkg::ctl_state_t state_q, state_d;
	logic [5:0] pc_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			foc_pkg::ST_IDLE: if (in_valid) state_d = foc_pkg::ST_RUN;
			foc_pkg::ST_RUN: if (sts.last) state_d = foc_pkg::ST_HOLD;
			foc_pkg::ST_HOLD: begin
				if (!out_stall) state_d = in_valid ? foc_pkg::ST_RUN : foc_pkg::ST_IDLE;
			end
			default: state_d = foc_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_stall = 1'b1;
		out_valid = 1'b0;
		cmd.start = 1'b0;
		cmd.step = 1'b0;
		cmd.pc = pc_q;
		case (state_q)
			foc_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				cmd.start = in_valid;
			end
			foc_pkg::ST_RUN: cmd.step = 1'b1;
			foc_pkg::ST_HOLD: begin
				out_valid = 1'b1;
				in_stall = out_stall;
				cmd.start = in_valid && !out_stall;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= foc_pkg::ST_IDLE;
			pc_q <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.start) pc_q <= '0;
			else if (cmd.step) pc_q <= pc_q + 6'd1;
		end
	end

	`FOC_ASSERT_IMP(a_run_no_out, state_q == foc_pkg::ST_RUN, !out_valid, "result during run")
	`FOC_ASSERT_NEXT(a_start_runs, cmd.start, state_q == foc_pkg::ST_RUN && pc_q == 6'd0,
		"start did not run")
	`FOC_ASSERT_IMP(a_pc_bound, state_q == foc_pkg::ST_RUN, pc_q <= foc_pkg::LastPc, "pc overrun")
endmodule
`default_nettype wire

[rtl/foc_datapath.sv]
// FOC datapath: shared 18x18 multiplier, accumulator, scratch registers.
// Depends on foc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module foc_datapath (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire foc_pkg::dp_cmd_t cmd,
	output foc_pkg::dp_sts_t sts,
	input  wire foc_pkg::in_item_t in_item,
	input  wire logic cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [15:0] cfg_data,
	output foc_pkg::out_item_t out_item
);
	localparam int W = foc_pkg::SineIdxW;
	localparam int Half = 1 << (foc_pkg::DutyBits - 1);
	localparam int Top = (1 << foc_pkg::DutyBits) - 1;

	// constant sine table
	logic signed [17:0] sine_rom [foc_pkg::SineTableDepth];
	for (genvar g = 0; g < foc_pkg::SineTableDepth; g++) begin : g_rom
		assign sine_rom[g] = foc_pkg::sine_entry(g);
	end

	logic [15:0] kp_q, ki_q;
	logic signed [15:0] dref_q, qref_q;
	logic [15:0] angle_q;
	logic signed [31:0] dint_q, qint_q;
	foc_pkg::in_item_t item_q;
	logic signed [17:0] s_q, c_q, beta_q, id_q, iq_q, vd_q, vq_q, va_q, vb_q;
	logic signed [17:0] errd_q, errq_q, v1_q, v2_q, v3_q, off_q;
	logic signed [47:0] acc_q;
	logic signed [35:0] prod_q;
	logic signed [17:0] ma, mb;
	logic signed [47:0] acc_in;
	logic [5:0] pc;
	logic [11:0] da_q, db_q, dc_q;

	assign pc = cmd.pc;
	assign sts.last = cmd.step && (pc == foc_pkg::LastPc);

	// operand select for the shared multiplier
	always_comb begin
		ma = '0;
		mb = '0;
		case (pc)
			6'd0: begin ma = 18'(item_q.phase_a_current) + 18'(item_q.phase_b_current)
				+ 18'(item_q.phase_b_current); mb = foc_pkg::InvSqrt3; end
			6'd2: begin ma = 18'(item_q.phase_a_current); mb = c_q; end
			6'd3: begin ma = beta_q; mb = s_q; end
			6'd5: begin ma = beta_q; mb = c_q; end
			6'd6: begin ma = 18'(item_q.phase_a_current); mb = s_q; end
			6'd9: begin ma = errd_q; mb = 18'({2'b00, ki_q}); end
			6'd11: begin ma = errq_q; mb = 18'({2'b00, ki_q}); end
			6'd13: begin ma = errd_q; mb = 18'({2'b00, kp_q}); end
			6'd15: begin ma = errq_q; mb = 18'({2'b00, kp_q}); end
			6'd17: begin ma = vd_q; mb = c_q; end
			6'd18: begin ma = vq_q; mb = s_q; end
			6'd20: begin ma = vd_q; mb = s_q; end
			6'd21: begin ma = vq_q; mb = c_q; end
			6'd23: begin ma = va_q; mb = foc_pkg::MinusHalf; end
			6'd24: begin ma = vb_q; mb = foc_pkg::HalfSqrt3; end
			6'd26: begin ma = va_q; mb = foc_pkg::MinusHalf; end
			6'd27: begin ma = vb_q; mb = foc_pkg::HalfSqrt3; end
			6'd31: begin ma = v1_q - off_q; mb = 18'(Half); end
			6'd33: begin ma = v2_q - off_q; mb = 18'(Half); end
			6'd35: begin ma = v3_q - off_q; mb = 18'(Half); end
			default: ;
		endcase
	end

	assign acc_in = 48'(prod_q);

	function automatic logic [11:0] duty_of(input logic signed [47:0] p);
		logic signed [63:0] r;
		logic signed [47:0] d;
		r = foc_pkg::rshr(64'(p), 12);
		d = 48'(Half) + 48'(r);
		if (d < 0) return '0;
		if (d > 48'(Top)) return 12'(Top);
		return d[11:0];
	endfunction

	function automatic logic signed [17:0] pi_v(input logic signed [47:0] p,
			input logic signed [31:0] integ);
		logic signed [63:0] t;
		t = foc_pkg::rshr(64'(p), 8) + foc_pkg::rshr(64'(integ), 16);
		return 18'(foc_pkg::sat16(t));
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [47:0] x);
		if (x > 48'sh7FFFFFFF) return 32'sh7FFFFFFF;
		if (x < -48'sh80000000) return 32'sh80000000;
		return x[31:0];
	endfunction

	logic signed [17:0] mn, mx;
	logic signed [18:0] sm;
	always_comb begin
		mn = v1_q; mx = v1_q;
		if (v2_q < mn) mn = v2_q;
		if (v3_q < mn) mn = v3_q;
		if (v2_q > mx) mx = v2_q;
		if (v3_q > mx) mx = v3_q;
		sm = 19'(mx) + 19'(mn);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q <= 16'd1280;
			ki_q <= 16'd655;
			dref_q <= '0;
			qref_q <= 16'sd6144;
		end else if (cfg_we) begin
			case (cfg_index)
				foc_pkg::RegKp: kp_q <= cfg_data;
				foc_pkg::RegKi: ki_q <= cfg_data;
				foc_pkg::RegDRef: dref_q <= cfg_data;
				foc_pkg::RegQRef: qref_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q <= '0;
			dint_q <= '0;
			qint_q <= '0;
		end else if (cmd.step) begin
			case (pc)
				6'd10: dint_q <= sat32(48'(dint_q) + acc_in);
				6'd12: qint_q <= sat32(48'(qint_q) + acc_in);
				6'd40: angle_q <= angle_q + item_q.angle_step;
				default: ;
			endcase
		end
	end

	// microcode steps: multiply registered, then consumed next step
	always_ff @(posedge clk) begin
		prod_q <= ma * mb;
		if (cmd.start) begin
			item_q <= in_item;
			s_q <= sine_rom[angle_q[15 -: W]];
			c_q <= sine_rom[W'(angle_q[15 -: W] + W'(1 << (W - 2)))];
		end else if (cmd.step) begin
			case (pc)
				6'd1: beta_q <= 18'(foc_pkg::sat16(foc_pkg::rshr(64'(prod_q), 15)));
				6'd3: acc_q <= acc_in;
				6'd4: id_q <= 18'(foc_pkg::sat16(foc_pkg::rshr(64'(acc_q + acc_in), 15)));
				6'd6: acc_q <= acc_in;
				6'd7: iq_q <= 18'(foc_pkg::sat16(foc_pkg::rshr(64'(acc_q - acc_in), 15)));
				6'd8: begin errd_q <= 18'(dref_q) - id_q; errq_q <= 18'(qref_q) - iq_q; end
				6'd14: vd_q <= pi_v(acc_in, dint_q);
				6'd16: vq_q <= pi_v(acc_in, qint_q);
				6'd18: acc_q <= acc_in;
				6'd19: va_q <= 18'(foc_pkg::sat16(foc_pkg::rshr(64'(acc_q - acc_in), 15)));
				6'd21: acc_q <= acc_in;
				6'd22: vb_q <= 18'(foc_pkg::sat16(foc_pkg::rshr(64'(acc_q + acc_in), 15)));
				6'd24: acc_q <= acc_in;
				6'd25: v2_q <= 18'(foc_pkg::rshr(64'(acc_q + acc_in), 15));
				6'd27: acc_q <= acc_in;
				6'd28: v3_q <= 18'(foc_pkg::rshr(64'(acc_q - acc_in), 15));
				6'd29: v1_q <= va_q;
				6'd30: off_q <= 18'(sm >>> 1);
				6'd32: da_q <= duty_of(acc_in);
				6'd34: db_q <= duty_of(acc_in);
				6'd36: dc_q <= duty_of(acc_in);
				default: ;
			endcase
		end
	end

	assign out_item.duty_a = da_q;
	assign out_item.duty_b = db_q;
	assign out_item.duty_c = dc_q;
	assign out_item.current_d = id_q[15:0];
	assign out_item.current_q = iq_q[15:0];
endmodule
`default_nettype wire

[rtl/foc_current_loop.sv]
// Top level of the FOC current loop: sequencer plus shared-multiplier datapath.
// Depends on foc_pkg, foc_ctrl, foc_datapath.
//  channel | direction | payload
//  in      | request   | in_item_t: phase currents, angle step
//  out     | result    | out_item_t: three duties, d/q currents
//  cfg     | write     | index 0..3, 16-bit data
// Each request is accepted, then runs 41 microcode steps on one 18x18 multiplier.
// The result is held in registers until taken; the next request is accepted
// in the cycle the result is taken. Reset clears gains, references,
// angle and integrators to their defaults.
`timescale 1ns / 1ps
`default_nettype none
module foc_current_loop (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire foc_pkg::in_item_t in_data,
	output logic out_valid,
	input  wire logic out_stall,
	output foc_pkg::out_item_t out_data,
	input  wire logic cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [15:0] cfg_data
);
	foc_pkg::dp_cmd_t cmd;
	foc_pkg::dp_sts_t sts;

	foc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .sts(sts)
	);

	foc_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .in_item(in_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.out_item(out_data)
	);
endmodule
`default_nettype wire

[tb/sv/foc_current_loop_tb.sv]
// Self-checking testbench for foc_current_loop: a directed table, register extremes, then random requests.
// Each result is checked against an independent predictor of the current loop.
// Depends on foc_pkg and foc_current_loop.
`timescale 1ns / 1ps
`default_nettype none
module foc_current_loop_tb;
	localparam int NumRandom = 1750;
	localparam longint CycleLimit = 2000000;
	localparam int Latency = 60;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	foc_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	foc_pkg::out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = foc_pkg::RegKp;
	logic [15:0] cfg_data = '0;

	foc_current_loop u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor state and register copies
	logic [15:0] kp_gain, ki_gain;
	logic signed [15:0] ref_d, ref_q;
	logic [15:0] angle;
	longint integ_d, integ_q;

	foc_pkg::out_item_t duty_queue[$];
	foc_pkg::out_item_t last_out = '0;
	int errors = 0;
	longint cycles = 0;
	bit long_hold = 1'b0;

	// round half up by 2^k, floor semantics on the signed value
	function automatic longint round_shift(longint x, int k);
		return (x + (longint'(1) << (k - 1))) >>> k;
	endfunction

	function automatic longint clamp(longint x, longint lo, longint hi);
		return x < lo ? lo : (x > hi ? hi : x);
	endfunction

	function automatic longint sine_of(logic [15:0] ang);
		longint idx, ph, quad, r, z, z2, t;
		idx = (longint'(ang) * foc_pkg::SineTableDepth) >> 16;
		ph = (idx * 65536) / foc_pkg::SineTableDepth;
		quad = (ph >> 14) & 3;
		r = ph & 16'h3FFF;
		z = (quad & 1) ? (16384 - r) * 2 : r * 2;
		z2 = round_shift(z * z, 15);
		t = 21315 - round_shift(2611 * z2, 15);
		t = 51472 - round_shift(t * z2, 15);
		t = round_shift(t * z, 15);
		return (quad & 2) ? -t : t;
	endfunction

	function automatic longint regulate(longint err, ref longint integ);
		integ = clamp(integ + err * longint'(ki_gain), -64'sd2147483648, 64'sd2147483647);
		return clamp(round_shift(err * longint'(kp_gain), 8) + round_shift(integ, 16),
			-32768, 32767);
	endfunction

	function automatic logic [11:0] duty_from(longint x);
		longint half, d;
		half = longint'(1) << (foc_pkg::DutyBits - 1);
		d = half + round_shift(x * half, 12);
		return 12'(clamp(d, 0, (longint'(1) << foc_pkg::DutyBits) - 1));
	endfunction

	// one control step: Clarke, Park, PI, inverse Park, SVPWM
	function automatic foc_pkg::out_item_t control_step(foc_pkg::in_item_t req);
		longint a, b, s, c, al, be, id, iq, vd, vq, va, vb, v1, v2, v3, mn, mx, sum, off;
		foc_pkg::out_item_t r;
		a = req.phase_a_current;
		b = req.phase_b_current;
		s = sine_of(angle);
		c = sine_of(angle + 16'd16384);
		al = a;
		be = clamp(round_shift((a + 2 * b) * 18919, 15), -32768, 32767);
		id = clamp(round_shift(al * c + be * s, 15), -32768, 32767);
		iq = clamp(round_shift(be * c - al * s, 15), -32768, 32767);
		vd = regulate(longint'(ref_d) - id, integ_d);
		vq = regulate(longint'(ref_q) - iq, integ_q);
		va = clamp(round_shift(vd * c - vq * s, 15), -32768, 32767);
		vb = clamp(round_shift(vd * s + vq * c, 15), -32768, 32767);
		v1 = va;
		v2 = round_shift(-16384 * va + 28378 * vb, 15);
		v3 = round_shift(-16384 * va - 28378 * vb, 15);
		mn = v1; mx = v1;
		if (v2 < mn) mn = v2;
		if (v3 < mn) mn = v3;
		if (v2 > mx) mx = v2;
		if (v3 > mx) mx = v3;
		sum = mx + mn;
		off = sum >>> 1;
		r.duty_a = duty_from(v1 - off);
		r.duty_b = duty_from(v2 - off);
		r.duty_c = duty_from(v3 - off);
		r.current_d = 16'(id);
		r.current_q = 16'(iq);
		angle = angle + 16'(req.angle_step);
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			foc_pkg::RegKp: kp_gain = val;
			foc_pkg::RegKi: ki_gain = val;
			foc_pkg::RegDRef: ref_d = val;
			foc_pkg::RegQRef: ref_q = val;
			default: ;
		endcase
	endtask

	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
		repeat (n) @(posedge clk);
	endtask

	// sends one request; expectation queued when it is accepted
	task automatic send_request(foc_pkg::in_item_t req, bit gaps);
		if (gaps && $urandom_range(0, 1)) idle_gap();
		@(posedge clk);
		in_valid <= 1'b1;
		in_data <= req;
		do @(posedge clk); while (in_stall);
		duty_queue.push_back(control_step(req));
		in_valid <= 1'b0;
	endtask

	task automatic drain();
		while (duty_queue.size() != 0) @(posedge clk);
		repeat (Latency) @(posedge clk);
	endtask

	// result checking
	always @(posedge clk) begin
		foc_pkg::out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			last_out = out_data;
			if (duty_queue.size() == 0) begin
				report_mismatch("result with nothing expected", 1, 0);
			end else begin
				want = duty_queue.pop_front();
				if (out_data.duty_a !== want.duty_a)
					report_mismatch("duty_a", out_data.duty_a, want.duty_a);
				if (out_data.duty_b !== want.duty_b)
					report_mismatch("duty_b", out_data.duty_b, want.duty_b);
				if (out_data.duty_c !== want.duty_c)
					report_mismatch("duty_c", out_data.duty_c, want.duty_c);
				if (out_data.current_d !== want.current_d)
					report_mismatch("current_d", out_data.current_d, want.current_d);
				if (out_data.current_q !== want.current_q)
					report_mismatch("current_q", out_data.current_q, want.current_q);
			end
		end
	end

	// receiver stalls: random gaps, or one long hold-off counted here
	always @(posedge clk) begin
		int hold;
		if (long_hold) begin
			out_stall <= 1'b1;
			for (hold = 0; hold < 400; hold++) @(posedge clk);
			long_hold = 1'b0;
			out_stall <= 1'b0;
		end else if ($urandom_range(0, 15) == 0) begin
			out_stall <= 1'b1;
			repeat (($urandom_range(0, 7) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3))
				@(posedge clk);
			out_stall <= 1'b0;
		end else if (out_stall) begin
			out_stall <= 1'b0;
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	typedef struct {
		logic [15:0] a, b, step;
		bit typed;
		logic [11:0] da, db, dc;
		logic [15:0] cd, cq;
	} table_row_t;

	table_row_t rows[] = '{
		// zero currents right after reset, angle 0: pure q demand, phases B and C clip
		'{16'sd0, 16'sd0, 16'sd0, 1'b1, 2048, 4095, 0, 0, 0},
		'{16'sh7FFF, 16'sh7FFF, 16'sd4096, 1'b0, 0, 0, 0, 0, 0},
		'{16'sh8000, 16'sh8000, 16'sh7FFF, 1'b0, 0, 0, 0, 0, 0},
		'{16'sh7FFF, 16'sh8000, 16'sh8000, 1'b0, 0, 0, 0, 0, 0},
		'{16'sh8000, 16'sh7FFF, 16'shFFFF, 1'b0, 0, 0, 0, 0, 0},
		'{16'sd4096, 16'sd0, 16'sd16384, 1'b0, 0, 0, 0, 0, 0},
		'{16'sd0, 16'sd4096, -16'sd16384, 1'b0, 0, 0, 0, 0, 0},
		'{16'shFFFF, 16'sh0001, 16'sd1, 1'b0, 0, 0, 0, 0, 0},
		'{16'sh5555, 16'shAAAA, 16'sh5555, 1'b0, 0, 0, 0, 0, 0},
		'{16'shAAAA, 16'sh5555, 16'shAAAA, 1'b0, 0, 0, 0, 0, 0}
	};

	initial begin
		foc_pkg::in_item_t req;
		foc_pkg::out_item_t got;
		int n, ph;
		kp_gain = 16'd1280;
		ki_gain = 16'd655;
		ref_d = 16'sd0;
		ref_q = 16'sd6144;
		angle = '0;
		integ_d = 0;
		integ_q = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed table; typed rows also checked against the values in the table
		foreach (rows[i]) begin
			req.phase_a_current = rows[i].a;
			req.phase_b_current = rows[i].b;
			req.angle_step = rows[i].step;
			send_request(req, 1'b0);
			if (rows[i].typed) begin
				drain();
				got = last_out;
				if (got.duty_a !== rows[i].da)
					report_mismatch("table duty_a", got.duty_a, rows[i].da);
				if (got.duty_b !== rows[i].db)
					report_mismatch("table duty_b", got.duty_b, rows[i].db);
				if (got.duty_c !== rows[i].dc)
					report_mismatch("table duty_c", got.duty_c, rows[i].dc);
				if (got.current_d !== rows[i].cd)
					report_mismatch("table current_d", got.current_d, rows[i].cd);
				if (got.current_q !== rows[i].cq)
					report_mismatch("table current_q", got.current_q, rows[i].cq);
			end
		end
		drain();

		// register extremes, each followed by a few requests
		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					write_reg(foc_pkg::RegKp, 16'hFFFF); write_reg(foc_pkg::RegKi, 16'hFFFF);
					write_reg(foc_pkg::RegDRef, 16'h7FFF); write_reg(foc_pkg::RegQRef, 16'h8000);
				end
				1: begin
					write_reg(foc_pkg::RegKp, 16'h0000); write_reg(foc_pkg::RegKi, 16'h0000);
					write_reg(foc_pkg::RegDRef, 16'h8000); write_reg(foc_pkg::RegQRef, 16'h7FFF);
				end
				2: begin
					write_reg(foc_pkg::RegKp, 16'h0100); write_reg(foc_pkg::RegKi, 16'h8000);
					write_reg(foc_pkg::RegDRef, 16'h0000); write_reg(foc_pkg::RegQRef, 16'h1000);
				end
				default: begin
					write_reg(foc_pkg::RegKp, 16'd1280); write_reg(foc_pkg::RegKi, 16'd655);
					write_reg(foc_pkg::RegDRef, 16'h0800); write_reg(foc_pkg::RegQRef, 16'h1800);
				end
			endcase
			repeat (6) begin
				req = foc_pkg::in_item_t'(48'({$urandom(), $urandom()}));
				send_request(req, 1'b0);
			end
			drain();
		end

		// random part with occasional register changes between phases
		for (n = 0; n < NumRandom; n++) begin
			req.phase_a_current = $urandom_range(0, 3) == 0 ? 16'($urandom())
				: 16'($signed($urandom_range(0, 16384)) - 8192);
			req.phase_b_current = $urandom_range(0, 3) == 0 ? 16'($urandom())
				: 16'($signed($urandom_range(0, 16384)) - 8192);
			req.angle_step = $urandom_range(0, 2) == 0 ? 16'($urandom())
				: 16'($urandom_range(0, 1024));
			if (n == 300) long_hold = 1'b1;
			send_request(req, 1'b1);
			if (n % 350 == 349) begin
				// sender waits for every outstanding result
				drain();
				write_reg(foc_pkg::RegKp, 16'($urandom()));
				write_reg(foc_pkg::RegKi, 16'($urandom_range(0, 4000)));
				write_reg(foc_pkg::RegDRef, 16'($urandom()));
				write_reg(foc_pkg::RegQRef, 16'($urandom()));
			end
		end
		drain();

		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
`default_nettype wire
